[rtl/quaternion_to_euler_angles_assert.svh]
// Assertion macros for the quaternion to Euler angle converter.
// Used by the port checker; needs clk and arst_n in scope.
`ifndef QUATERNION_TO_EULER_ANGLES_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_ASSERT_SVH

// same-cycle implication
`define QTE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define QTE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

[rtl/qte_pkg.sv]
// Package for the quaternion to Euler angle converter.
// Widths, angle constants, CORDIC arctangent table and rounding helper.
package qte_pkg;

	localparam int IN_W              = 16;
	localparam int ANG_W             = 16;
	localparam int PITCH_W           = 15;
	localparam int PROD_W            = 32;
	localparam int SUM_W             = 34;
	localparam int SP_W              = 29;
	localparam int SQ_W              = 56;
	localparam int RAD_W             = 57;
	localparam int ROOT_W            = 58;
	localparam int SQRT_STEPS        = 29;
	localparam int CW                = 36;
	localparam int ZW                = 24;
	localparam int CORDIC_STAGES_DEF = 16;

	localparam logic signed [SUM_W-1:0] ONE_Q28     = SUM_W'(1) <<< 28;
	localparam logic signed [ZW-1:0]    HALF_PI_Q20 = ZW'(1647099);
	localparam logic signed [ANG_W-1:0] PI_Q13      = ANG_W'(25736);
	localparam logic signed [ANG_W-1:0] HALF_PI_Q13 = ANG_W'(12868);
	localparam logic signed [ZW:0]      RND_HALF    = (ZW+1)'(64);

	typedef struct packed {
		logic signed [SUM_W-1:0] sr;
		logic signed [SUM_W-1:0] cr;
		logic signed [SUM_W-1:0] sy;
		logic signed [SUM_W-1:0] cy;
		logic signed [SP_W-1:0]  sp;
		logic                    sat_hi;
		logic                    sat_lo;
	} carry_t;

	function automatic logic signed [ZW-1:0] atan_entry(input int unsigned idx);
		logic signed [ZW-1:0] r;
		case (idx)
			0:       r = ZW'(823550);
			1:       r = ZW'(486170);
			2:       r = ZW'(256879);
			3:       r = ZW'(130396);
			4:       r = ZW'(65451);
			5:       r = ZW'(32757);
			6:       r = ZW'(16383);
			7:       r = ZW'(8192);
			8:       r = ZW'(4096);
			9:       r = ZW'(2048);
			10:      r = ZW'(1024);
			11:      r = ZW'(512);
			12:      r = ZW'(256);
			13:      r = ZW'(128);
			14:      r = ZW'(64);
			15:      r = ZW'(32);
			16:      r = ZW'(16);
			17:      r = ZW'(8);
			18:      r = ZW'(4);
			19:      r = ZW'(2);
			20:      r = ZW'(1);
			default: r = '0;
		endcase
		return r;
	endfunction

	// round Q20 angle to Q13 (half up) and clamp to +/- lim
	function automatic logic signed [ANG_W-1:0] round_clamp(
		input logic signed [ZW-1:0]    z,
		input logic signed [ANG_W-1:0] lim
	);
		logic signed [ZW:0] zx;
		logic signed [ZW:0] t;
		logic signed [ZW:0] lx;
		logic signed [ANG_W-1:0] r;
		zx = z;
		lx = lim;
		t  = (zx + RND_HALF) >>> 7;
		if (t > lx)
			r = lim;
		else if (t < -lx)
			r = -lim;
		else
			r = t[ANG_W-1:0];
		return r;
	endfunction

endpackage

[rtl/qte_cordic.sv]
// Pipelined vectoring-mode CORDIC arctangent, one iteration per stage.
// Depends on qte_pkg for the arctangent table and the half-pi constant.
module qte_cordic #(
	parameter int N  = qte_pkg::CORDIC_STAGES_DEF,
	parameter int CW = qte_pkg::CW,
	parameter int ZW = qte_pkg::ZW
) (
	input  logic                 clk,
	input  logic [N:0]           en,
	input  logic signed [CW-1:0] y_in,
	input  logic signed [CW-1:0] x_in,
	output logic signed [ZW-1:0] z_out
);

	logic signed [CW-1:0] x_s [0:N];
	logic signed [CW-1:0] y_s [0:N];
	logic signed [ZW-1:0] z_s [0:N];
	logic                 zf_s [0:N];

	// quadrant pre-rotation
	always_ff @(posedge clk) begin
		if (en[0]) begin
			zf_s[0] <= (x_in == '0) && (y_in == '0);
			if (x_in < 0) begin
				if (y_in >= 0) begin
					x_s[0] <= y_in;
					y_s[0] <= -x_in;
					z_s[0] <= qte_pkg::HALF_PI_Q20;
				end else begin
					x_s[0] <= -y_in;
					y_s[0] <= x_in;
					z_s[0] <= -qte_pkg::HALF_PI_Q20;
				end
			end else begin
				x_s[0] <= x_in;
				y_s[0] <= y_in;
				z_s[0] <= '0;
			end
		end
	end

	for (genvar i = 1; i <= N; i++) begin : g_iter
		logic signed [CW-1:0] xs;
		logic signed [CW-1:0] ys;
		assign xs = x_s[i-1] >>> (i-1);
		assign ys = y_s[i-1] >>> (i-1);
		always_ff @(posedge clk) begin
			if (en[i]) begin
				zf_s[i] <= zf_s[i-1];
				if (y_s[i-1] < 0) begin
					x_s[i] <= x_s[i-1] - ys;
					y_s[i] <= y_s[i-1] + xs;
					z_s[i] <= z_s[i-1] - qte_pkg::atan_entry(i-1);
				end else begin
					x_s[i] <= x_s[i-1] + ys;
					y_s[i] <= y_s[i-1] - xs;
					z_s[i] <= z_s[i-1] + qte_pkg::atan_entry(i-1);
				end
			end
		end
	end

	assign z_out = zf_s[N] ? '0 : z_s[N];

endmodule

[rtl/quaternion_to_euler_angles.sv]
// Quaternion (Q2.14) to ZYX Euler angles (Q3.13 radians; pitch Q2.13), fully pipelined.
// Depends on qte_pkg and qte_cordic.
//
// Input channel: quat_w/x/y/z with in_valid/in_ready; output channel:
// roll_angle, pitch_angle, yaw_angle with out_valid/out_ready.
// A transaction passes through products, quadratic sums, pitch square,
// radicand, a 29-stage square root for the pitch cosine, then the CORDIC
// pre-rotation and one stage per CORDIC iteration, then rounding and clamping.
// One transaction is accepted per cycle while in_ready is high. Each full
// stage holds while the stage after it is full and stalled, so when
// out_ready is low the pipeline keeps accepting until its empty stages are
// filled; nothing is lost or repeated. Reset clears all valid bits; the
// pipeline comes up empty.
// atan2(0,0) gives 0; pitch saturates to +/- pi/2 when |2(wy-zx)| >= 1.
module quaternion_to_euler_angles #(
	parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [qte_pkg::IN_W-1:0]       quat_w,
	input  logic signed [qte_pkg::IN_W-1:0]       quat_x,
	input  logic signed [qte_pkg::IN_W-1:0]       quat_y,
	input  logic signed [qte_pkg::IN_W-1:0]       quat_z,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [qte_pkg::ANG_W-1:0]      roll_angle,
	output logic signed [qte_pkg::PITCH_W-1:0]    pitch_angle,
	output logic signed [qte_pkg::ANG_W-1:0]      yaw_angle
);

	localparam int NS    = qte_pkg::SQRT_STEPS;
	localparam int S_PRE = 5 + NS;
	localparam int LAST  = S_PRE + CORDIC_STAGES + 1;
	localparam int PW    = qte_pkg::PROD_W;
	localparam int SW    = qte_pkg::SUM_W;
	localparam int CW    = qte_pkg::CW;
	localparam int ZW    = qte_pkg::ZW;

	logic [LAST:1]   vld;
	logic [LAST:0]   vpipe;
	logic [LAST+1:1] en;

	assign vpipe         = {vld, in_valid};
	assign en[LAST+1]    = out_ready;
	assign in_ready      = en[1];
	assign out_valid     = vld[LAST];

	for (genvar i = 1; i <= LAST; i++) begin : g_vld
		assign en[i] = !vld[i] || en[i+1];
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld[i] <= 1'b0;
			else if (en[i])
				vld[i] <= vpipe[i-1];
		end
	end

	// stage 1: products
	logic signed [PW-1:0] wx_s1, yz_s1, xx_s1, yy_s1, wy_s1, zx_s1, wz_s1, xy_s1, zz_s1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			wx_s1 <= quat_w * quat_x;
			yz_s1 <= quat_y * quat_z;
			xx_s1 <= quat_x * quat_x;
			yy_s1 <= quat_y * quat_y;
			wy_s1 <= quat_w * quat_y;
			zx_s1 <= quat_z * quat_x;
			wz_s1 <= quat_w * quat_z;
			xy_s1 <= quat_x * quat_y;
			zz_s1 <= quat_z * quat_z;
		end
	end

	// stage 2: quadratic sums, Q28
	logic signed [SW-1:0] sr_s2, cr_s2, sp_s2, sy_s2, cy_s2;

	function automatic logic signed [SW-1:0] dbl_sum(
		input logic signed [PW-1:0] a,
		input logic signed [PW-1:0] b
	);
		logic signed [SW-1:0] ax;
		logic signed [SW-1:0] bx;
		ax = a;
		bx = b;
		return (ax + bx) <<< 1;
	endfunction

	always_ff @(posedge clk) begin
		if (en[2]) begin
			sr_s2 <= dbl_sum(wx_s1, yz_s1);
			cr_s2 <= qte_pkg::ONE_Q28 - dbl_sum(xx_s1, yy_s1);
			sp_s2 <= dbl_sum(wy_s1, -zx_s1);
			sy_s2 <= dbl_sum(wz_s1, xy_s1);
			cy_s2 <= qte_pkg::ONE_Q28 - dbl_sum(yy_s1, zz_s1);
		end
	end

	// stage 3: pitch saturation and square
	qte_pkg::carry_t car_s3;
	logic [qte_pkg::SQ_W-1:0] sq_s3;
	logic                     hi_c, lo_c;
	logic signed [qte_pkg::SP_W-1:0]   sp_in;
	logic signed [2*qte_pkg::SP_W-1:0] sp_sq;

	assign hi_c  = sp_s2 >= qte_pkg::ONE_Q28;
	assign lo_c  = sp_s2 <= -qte_pkg::ONE_Q28;
	assign sp_in = (hi_c || lo_c) ? '0 : sp_s2[qte_pkg::SP_W-1:0];
	assign sp_sq = sp_in * sp_in;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			car_s3.sr     <= sr_s2;
			car_s3.cr     <= cr_s2;
			car_s3.sy     <= sy_s2;
			car_s3.cy     <= cy_s2;
			car_s3.sp     <= sp_in;
			car_s3.sat_hi <= hi_c;
			car_s3.sat_lo <= lo_c;
			sq_s3         <= sp_sq[qte_pkg::SQ_W-1:0];
		end
	end

	// stage 4: radicand; stages 5..4+NS: one root bit per stage
	logic [qte_pkg::RAD_W-1:0]  rad_s  [0:NS];
	logic [qte_pkg::ROOT_W-1:0] root_s [0:NS];
	qte_pkg::carry_t            car_s  [0:NS];

	always_ff @(posedge clk) begin
		if (en[4]) begin
			rad_s[0]  <= (qte_pkg::RAD_W'(1) << 56) - {1'b0, sq_s3};
			root_s[0] <= '0;
			car_s[0]  <= car_s3;
		end
	end

	for (genvar k = 0; k < NS; k++) begin : g_sqrt
		localparam logic [qte_pkg::ROOT_W-1:0] BITV = qte_pkg::ROOT_W'(1) << (56 - 2*k);
		logic [qte_pkg::ROOT_W-1:0] tr;
		logic                       ge;
		assign tr = root_s[k] + BITV;
		assign ge = {1'b0, rad_s[k]} >= tr;
		always_ff @(posedge clk) begin
			if (en[5+k]) begin
				car_s[k+1] <= car_s[k];
				if (ge) begin
					rad_s[k+1]  <= rad_s[k] - tr[qte_pkg::RAD_W-1:0];
					root_s[k+1] <= (root_s[k] >> 1) + BITV;
				end else begin
					rad_s[k+1]  <= rad_s[k];
					root_s[k+1] <= root_s[k] >> 1;
				end
			end
		end
	end

	// CORDIC lanes
	logic signed [CW-1:0] roll_y, roll_x, yaw_y, yaw_x, pit_y, pit_x;
	logic signed [ZW-1:0] roll_z, yaw_z, pit_z;

	assign roll_y = {{(CW-SW){car_s[NS].sr[SW-1]}}, car_s[NS].sr};
	assign roll_x = {{(CW-SW){car_s[NS].cr[SW-1]}}, car_s[NS].cr};
	assign yaw_y  = {{(CW-SW){car_s[NS].sy[SW-1]}}, car_s[NS].sy};
	assign yaw_x  = {{(CW-SW){car_s[NS].cy[SW-1]}}, car_s[NS].cy};
	assign pit_y  = {{(CW-qte_pkg::SP_W){car_s[NS].sp[qte_pkg::SP_W-1]}}, car_s[NS].sp};
	assign pit_x  = {{(CW-qte_pkg::SP_W){1'b0}}, root_s[NS][qte_pkg::SP_W-1:0]};

	qte_cordic #(.N(CORDIC_STAGES), .CW(CW), .ZW(ZW)) u_roll (
		.clk  (clk),
		.en   (en[S_PRE +: CORDIC_STAGES+1]),
		.y_in (roll_y),
		.x_in (roll_x),
		.z_out(roll_z)
	);

	qte_cordic #(.N(CORDIC_STAGES), .CW(CW), .ZW(ZW)) u_pitch (
		.clk  (clk),
		.en   (en[S_PRE +: CORDIC_STAGES+1]),
		.y_in (pit_y),
		.x_in (pit_x),
		.z_out(pit_z)
	);

	qte_cordic #(.N(CORDIC_STAGES), .CW(CW), .ZW(ZW)) u_yaw (
		.clk  (clk),
		.en   (en[S_PRE +: CORDIC_STAGES+1]),
		.y_in (yaw_y),
		.x_in (yaw_x),
		.z_out(yaw_z)
	);

	// saturation flags alongside the CORDIC stages
	logic [1:0] sat_s [0:CORDIC_STAGES];

	always_ff @(posedge clk) begin
		if (en[S_PRE])
			sat_s[0] <= {car_s[NS].sat_hi, car_s[NS].sat_lo};
	end

	for (genvar j = 1; j <= CORDIC_STAGES; j++) begin : g_sat
		always_ff @(posedge clk) begin
			if (en[S_PRE+j])
				sat_s[j] <= sat_s[j-1];
		end
	end

	// last stage: round, clamp, saturate
	logic signed [qte_pkg::ANG_W-1:0]   roll_sl, yaw_sl, pit_r;
	logic signed [qte_pkg::PITCH_W-1:0] pitch_sl;

	assign pit_r = qte_pkg::round_clamp(pit_z, qte_pkg::HALF_PI_Q13);

	always_ff @(posedge clk) begin
		if (en[LAST]) begin
			roll_sl <= qte_pkg::round_clamp(roll_z, qte_pkg::PI_Q13);
			yaw_sl  <= qte_pkg::round_clamp(yaw_z, qte_pkg::PI_Q13);
			if (sat_s[CORDIC_STAGES][1])
				pitch_sl <= qte_pkg::PITCH_W'(qte_pkg::HALF_PI_Q13);
			else if (sat_s[CORDIC_STAGES][0])
				pitch_sl <= qte_pkg::PITCH_W'(-qte_pkg::HALF_PI_Q13);
			else
				pitch_sl <= pit_r[qte_pkg::PITCH_W-1:0];
		end
	end

	assign roll_angle  = roll_sl;
	assign pitch_angle = pitch_sl;
	assign yaw_angle   = yaw_sl;

endmodule

[rtl/qte_checker.sv]
// Port-level checker for the quaternion to Euler angle converter.
// Depends on qte_pkg and quaternion_to_euler_angles_assert.svh; bound to the top level.
`include "quaternion_to_euler_angles_assert.svh"

module qte_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic signed [qte_pkg::IN_W-1:0]    quat_w,
	input logic signed [qte_pkg::IN_W-1:0]    quat_x,
	input logic signed [qte_pkg::IN_W-1:0]    quat_y,
	input logic signed [qte_pkg::IN_W-1:0]    quat_z,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic signed [qte_pkg::ANG_W-1:0]   roll_angle,
	input logic signed [qte_pkg::PITCH_W-1:0] pitch_angle,
	input logic signed [qte_pkg::ANG_W-1:0]   yaw_angle
);

	`QTE_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(roll_angle) && $stable(pitch_angle) && $stable(yaw_angle), "stalled result changed")
	`QTE_ASSERT_NOW(a_ready, !out_valid || out_ready, in_ready, "input blocked with output free")
	`QTE_ASSERT_NOW(a_pitch_rng, out_valid, pitch_angle <= 15'sd12868 && pitch_angle >= -15'sd12868, "pitch out of range")
	`QTE_ASSERT_NOW(a_ry_rng, out_valid, roll_angle <= 16'sd25736 && roll_angle >= -16'sd25736 && yaw_angle <= 16'sd25736 && yaw_angle >= -16'sd25736, "roll or yaw out of range")

endmodule

bind quaternion_to_euler_angles qte_checker u_qte_checker (.*);

[tb/sv/tb_top.sv]
// Testbench for quaternion_to_euler_angles: directed and random quaternions with
// random idling on both channels, checked against an in-bench fixed-point predictor.
// Depends on qte_pkg and the converter RTL.
`timescale 1ns / 1ps

module tb_top;

	localparam int STAGES    = qte_pkg::CORDIC_STAGES_DEF;
	localparam int LATENCY   = 35 + STAGES;
	localparam int MAX_WAIT  = 18;
	localparam int N_RANDOM  = 880;
	localparam longint CYCLE_LIMIT = 400000;
	localparam longint ONE28     = 64'sd1 <<< 28;
	localparam longint HPI20     = 64'sd1647099;
	localparam longint PI13      = 64'sd25736;
	localparam longint HPI13     = 64'sd12868;

	typedef struct {
		logic signed [qte_pkg::ANG_W-1:0]   roll;
		logic signed [qte_pkg::PITCH_W-1:0] pitch;
		logic signed [qte_pkg::ANG_W-1:0]   yaw;
	} euler_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [qte_pkg::IN_W-1:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [qte_pkg::ANG_W-1:0] roll_angle, yaw_angle;
	logic signed [qte_pkg::PITCH_W-1:0] pitch_angle;

	euler_t angles_due[$];
	int errors = 0;
	longint cycles = 0;
	bit sink_stalls = 1'b1;

	quaternion_to_euler_angles #(.CORDIC_STAGES(STAGES)) u_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic longint clampl(longint v, longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	function automatic longint vector_angle(longint y, longint x);
		longint z, t, xs, ys;
		z = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = HPI20;
			end else begin
				t = x; x = -y; y = t; z = -HPI20;
			end
		end
		for (int i = 0; i < STAGES && i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y < 0) begin
				x -= ys; y += xs; z -= longint'(qte_pkg::atan_entry(i));
			end else begin
				x += ys; y -= xs; z += longint'(qte_pkg::atan_entry(i));
			end
		end
		return clampl((z + 64) >>> 7, PI13);
	endfunction

	function automatic longint int_root(longint v);
		longint r, b;
		r = 0;
		b = 64'sd1 <<< 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >>> 1) + b;
			end else
				r >>>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function automatic euler_t euler_of(logic signed [qte_pkg::IN_W-1:0] qw, qx, qy, qz);
		longint w, x, y, z, sr, cr, sp, sy, cy, p;
		euler_t e;
		w = qw; x = qx; y = qy; z = qz;
		sr = 2 * (w * x + y * z);
		cr = ONE28 - 2 * (x * x + y * y);
		sp = 2 * (w * y - z * x);
		sy = 2 * (w * z + x * y);
		cy = ONE28 - 2 * (y * y + z * z);
		if (sp >= ONE28) p = HPI13;
		else if (sp <= -ONE28) p = -HPI13;
		else p = clampl(vector_angle(sp, int_root((64'sd1 <<< 56) - sp * sp)), HPI13);
		e.roll = qte_pkg::ANG_W'(vector_angle(sr, cr));
		e.pitch = qte_pkg::PITCH_W'(p);
		e.yaw = qte_pkg::ANG_W'(vector_angle(sy, cy));
		return e;
	endfunction

	// drives one transaction; valid stays high afterwards until the next call or end_input
	task automatic send_quat(input int qw, qx, qy, qz);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, MAX_WAIT);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		quat_w <= qte_pkg::IN_W'(qw); quat_x <= qte_pkg::IN_W'(qx);
		quat_y <= qte_pkg::IN_W'(qy); quat_z <= qte_pkg::IN_W'(qz);
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		angles_due.push_back(euler_of(qte_pkg::IN_W'(qw), qte_pkg::IN_W'(qx),
			qte_pkg::IN_W'(qy), qte_pkg::IN_W'(qz)));
	endtask

	task automatic end_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// sink: draws a stall per transaction
	initial begin
		int hold;
		forever begin
			@(negedge clk);
			hold = sink_stalls ? $urandom_range(0, MAX_WAIT) : 0;
			if (hold != 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		euler_t e;
		if (arst_n && out_valid && out_ready) begin
			if (angles_due.size() == 0) begin
				$error("unexpected transaction roll=%0d pitch=%0d yaw=%0d",
					roll_angle, pitch_angle, yaw_angle);
				errors++;
			end else begin
				e = angles_due.pop_front();
				if (roll_angle !== e.roll) begin
					$error("roll_angle expected %0d actual %0d", e.roll, roll_angle);
					errors++;
				end
				if (pitch_angle !== e.pitch) begin
					$error("pitch_angle expected %0d actual %0d", e.pitch, pitch_angle);
					errors++;
				end
				if (yaw_angle !== e.yaw) begin
					$error("yaw_angle expected %0d actual %0d", e.yaw, yaw_angle);
					errors++;
				end
			end
		end
	end

	task automatic test_extremes();
		send_quat(16384, 0, 0, 0);
		send_quat(0, 0, 0, 0);
		send_quat(-16384, 0, 0, 0);
		send_quat(0, 16384, 0, 0);
		send_quat(0, 0, 16384, 0);
		send_quat(0, 0, 0, 16384);
		send_quat(0, -16384, 0, 0);
		send_quat(0, 0, -16384, 0);
		send_quat(11585, 0, 11585, 0);
		send_quat(11585, 0, -11585, 0);
		send_quat(11586, 0, 11586, 0);
		send_quat(11585, 0, 11584, 0);
		send_quat(32767, 32767, 32767, 32767);
		send_quat(-32768, -32768, -32768, -32768);
		send_quat(-32768, 32767, -32768, 32767);
		send_quat(8192, 8192, 8192, 8192);
		send_quat(0, 11585, 0, 11585);
		send_quat(-1, -1, -1, -1);
		send_quat(21845, -21846, 21845, -21846);
		end_input();
	endtask

	function automatic int comp(real v);
		return $rtoi(v * 16384.0);
	endfunction

	task automatic test_random();
		real a, b, c, d, n;
		for (int i = 0; i < N_RANDOM; i++) begin
			if ($urandom_range(0, 4) == 0)
				send_quat(int'($urandom), int'($urandom), int'($urandom), int'($urandom));
			else begin
				a = real'($urandom_range(0, 2000)) - 1000.0;
				b = real'($urandom_range(0, 2000)) - 1000.0;
				c = real'($urandom_range(0, 2000)) - 1000.0;
				d = real'($urandom_range(0, 2000)) - 1000.0;
				n = $sqrt(a * a + b * b + c * c + d * d);
				if (n == 0.0) n = 1.0;
				send_quat(comp(a / n), comp(b / n), comp(c / n), comp(d / n));
			end
		end
		end_input();
	endtask

	task automatic test_back_to_back();
		sink_stalls = 1'b0;
		@(negedge clk);
		in_valid <= 1'b1;
		for (int i = 0; i < 40; i++) begin
			quat_w <= qte_pkg::IN_W'($urandom); quat_x <= qte_pkg::IN_W'($urandom);
			quat_y <= qte_pkg::IN_W'($urandom); quat_z <= qte_pkg::IN_W'($urandom);
			@(posedge clk);
			while (!in_ready) @(posedge clk);
			angles_due.push_back(euler_of(quat_w, quat_x, quat_y, quat_z));
			@(negedge clk);
		end
		in_valid <= 1'b0;
		sink_stalls = 1'b1;
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		test_extremes();
		test_back_to_back();
		test_random();
		while (angles_due.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
